>>> rtl/c8enc_pkg.sv
// Package with shared types, codes and slot-matching helper for the CHIP-8 encoder.
`timescale 1ns / 1ps

package c8enc_pkg;

  // Mnemonic codes
  localparam logic [4:0] ACT_CLS  = 5'd0;
  localparam logic [4:0] ACT_RET  = 5'd1;
  localparam logic [4:0] ACT_SYS  = 5'd2;
  localparam logic [4:0] ACT_JP   = 5'd3;
  localparam logic [4:0] ACT_CALL = 5'd4;
  localparam logic [4:0] ACT_SE   = 5'd5;
  localparam logic [4:0] ACT_SNE  = 5'd6;
  localparam logic [4:0] ACT_LD   = 5'd7;
  localparam logic [4:0] ACT_ADD  = 5'd8;
  localparam logic [4:0] ACT_OR   = 5'd9;
  localparam logic [4:0] ACT_AND  = 5'd10;
  localparam logic [4:0] ACT_XOR  = 5'd11;
  localparam logic [4:0] ACT_SUB  = 5'd12;
  localparam logic [4:0] ACT_SHR  = 5'd13;
  localparam logic [4:0] ACT_SUBN = 5'd14;
  localparam logic [4:0] ACT_SHL  = 5'd15;
  localparam logic [4:0] ACT_RND  = 5'd16;
  localparam logic [4:0] ACT_DRW  = 5'd17;
  localparam logic [4:0] ACT_SKP  = 5'd18;
  localparam logic [4:0] ACT_SKNP = 5'd19;

  // Argument kinds
  localparam logic [3:0] KIND_V   = 4'd0;
  localparam logic [3:0] KIND_I   = 4'd1;
  localparam logic [3:0] KIND_A   = 4'd2;
  localparam logic [3:0] KIND_IND = 4'd3;
  localparam logic [3:0] KIND_KEY = 4'd4;
  localparam logic [3:0] KIND_B   = 4'd5;
  localparam logic [3:0] KIND_N   = 4'd6;
  localparam logic [3:0] KIND_DT  = 4'd7;
  localparam logic [3:0] KIND_ST  = 4'd8;

  // I-register operand values
  localparam logic [11:0] IREG_I = 12'd0;
  localparam logic [11:0] IREG_F = 12'd1;
  localparam logic [11:0] IREG_B = 12'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef struct packed {
    logic [4:0]  action;
    logic [1:0]  num_args;
    logic [3:0]  first_kind;
    logic [11:0] first_value;
    logic [3:0]  second_kind;
    logic [11:0] second_value;
    logic [3:0]  third_kind;
    logic [11:0] third_value;
  } instr_t;

  typedef struct packed {
    logic [15:0] machine_word;
    logic [1:0]  status;
  } result_t;

  // An address slot also takes a byte or nibble, a byte slot takes a nibble.
  function automatic logic fits(input logic [3:0] slot, input logic [3:0] kind);
    logic ok;
    if (kind == slot) begin
      ok = (kind <= KIND_ST);
    end else if (slot == KIND_A) begin
      ok = (kind == KIND_B) || (kind == KIND_N);
    end else if (slot == KIND_B) begin
      ok = (kind == KIND_N);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

>>> rtl/chip8_instruction_encoder.sv
// Top level of the CHIP-8 instruction encoder: input register, encoder, result register.
`timescale 1ns / 1ps

// Channel  Dir  tdata bits                                      tuser bits
// in_      in   action, num_args, first/second/third_value      first/second/third_kind
// out_     out  machine_word, status                            -
//
// One instruction per cycle sustained while out_tready stays high; an input
// transfer is registered in the input register, then in the result register,
// and out_tvalid rises once the result register holds it.
// Throughput is set by the single encoder pass between the two registers.
// rst_n is synchronous and active low; it drops both valid flags.
// A stalled out_tready holds the result register; the input register still
// takes one more instruction before in_tready falls.

module chip8_instruction_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] action, [6:5] num_args, [18:7] first_value, [30:19] second_value,
  // [42:31] third_value, [47:43] zero
  input  logic [47:0] in_tdata,
  // [3:0] first_kind, [7:4] second_kind, [11:8] third_kind
  input  logic [11:0] in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] machine_word, [17:16] status, [23:18] zero
  output logic [23:0] out_tdata
);

  logic                s1_vld_r, s1_vld_nxt;
  c8enc_pkg::instr_t   s1_r;
  logic                o_vld_r, o_vld_nxt;
  c8enc_pkg::result_t  o_r;
  c8enc_pkg::result_t  enc_res;
  logic                o_free;
  logic                s1_adv;
  logic                in_xfer;

  // Advance the input stage whenever the result register is free or draining
  assign o_free    = !o_vld_r || out_tready;
  assign s1_adv    = s1_vld_r && o_free;
  assign in_tready = !s1_vld_r || o_free;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer)     s1_vld_nxt = 1'b1;
    else if (s1_adv) s1_vld_nxt = 1'b0;
    o_vld_nxt = o_vld_r;
    if (s1_adv)      o_vld_nxt = 1'b1;
    else if (out_tready) o_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      o_vld_r  <= o_vld_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.action       <= in_tdata[4:0];
      s1_r.num_args     <= in_tdata[6:5];
      s1_r.first_value  <= in_tdata[18:7];
      s1_r.second_value <= in_tdata[30:19];
      s1_r.third_value  <= in_tdata[42:31];
      s1_r.first_kind   <= in_tuser[3:0];
      s1_r.second_kind  <= in_tuser[7:4];
      s1_r.third_kind   <= in_tuser[11:8];
    end
    if (s1_adv) begin
      o_r <= enc_res;
    end
  end

  c8enc_core u_core (
    .instr  (s1_r),
    .result (enc_res)
  );

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {6'b0, o_r.status, o_r.machine_word};

  // A failed encode never carries a word
  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && o_r.status != c8enc_pkg::ST_OK) |-> (o_r.machine_word == 16'h0000))
    else $error("nonzero word with failing status");

  // Status code 3 is never produced
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_r.status != 2'd3))
    else $error("illegal status code");

  // An instruction in the input stage with a free result register lands next cycle
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && o_free) |=> out_tvalid)
    else $error("input stage did not advance");

  // An empty input stage always takes a transfer
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_tready)
    else $error("input stage empty but not ready");

  // A stalled result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(o_r)))
    else $error("stalled result changed");

endmodule

>>> rtl/c8enc_core.sv
// Combinational pattern check and word packing for one CHIP-8 instruction.
`timescale 1ns / 1ps

module c8enc_core (
  input  c8enc_pkg::instr_t  instr,
  output c8enc_pkg::result_t result
);

  logic [1:0]  cnt;
  logic [3:0]  k0, k1, k2;
  logic [11:0] v0, v1, v2;
  logic [15:0] rx, ry, ry8, kk, a0, a1;
  logic        p0, p1a, p1v, p2va, p2vb, p2vv, p2ia, p2vdt, p2vkey;
  logic        p2dtv, p2stv, p2iv, p2indv, p2vind, p3vvn;
  logic [15:0] w;
  logic [1:0]  st;

  assign cnt = instr.num_args;
  assign k0  = instr.first_kind;
  assign k1  = instr.second_kind;
  assign k2  = instr.third_kind;
  assign v0  = instr.first_value;
  assign v1  = instr.second_value;
  assign v2  = instr.third_value;

  assign rx  = {4'b0, v0[3:0], 8'b0};
  assign ry  = {8'b0, v1[3:0], 4'b0};
  assign ry8 = {4'b0, v1[3:0], 8'b0};
  assign kk  = {8'b0, v1[7:0]};
  assign a0  = {4'b0, v0};
  assign a1  = {4'b0, v1};

  // Pattern hits: count must equal the pattern length
  assign p0     = (cnt == 2'd0);
  assign p1a    = (cnt == 2'd1) && c8enc_pkg::fits(c8enc_pkg::KIND_A, k0);
  assign p1v    = (cnt == 2'd1) && c8enc_pkg::fits(c8enc_pkg::KIND_V, k0);
  assign p2va   = (cnt == 2'd2) && c8enc_pkg::fits(c8enc_pkg::KIND_V, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_A, k1);
  assign p2vb   = (cnt == 2'd2) && c8enc_pkg::fits(c8enc_pkg::KIND_V, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_B, k1);
  assign p2vv   = (cnt == 2'd2) && c8enc_pkg::fits(c8enc_pkg::KIND_V, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_V, k1);
  assign p2ia   = (cnt == 2'd2) && c8enc_pkg::fits(c8enc_pkg::KIND_I, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_A, k1);
  assign p2vdt  = (cnt == 2'd2) && c8enc_pkg::fits(c8enc_pkg::KIND_V, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_DT, k1);
  assign p2vkey = (cnt == 2'd2) && c8enc_pkg::fits(c8enc_pkg::KIND_V, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_KEY, k1);
  assign p2dtv  = (cnt == 2'd2) && c8enc_pkg::fits(c8enc_pkg::KIND_DT, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_V, k1);
  assign p2stv  = (cnt == 2'd2) && c8enc_pkg::fits(c8enc_pkg::KIND_ST, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_V, k1);
  assign p2iv   = (cnt == 2'd2) && c8enc_pkg::fits(c8enc_pkg::KIND_I, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_V, k1);
  assign p2indv = (cnt == 2'd2) && c8enc_pkg::fits(c8enc_pkg::KIND_IND, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_V, k1);
  assign p2vind = (cnt == 2'd2) && c8enc_pkg::fits(c8enc_pkg::KIND_V, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_IND, k1);
  assign p3vvn  = (cnt == 2'd3) && c8enc_pkg::fits(c8enc_pkg::KIND_V, k0)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_V, k1)
                  && c8enc_pkg::fits(c8enc_pkg::KIND_N, k2);

  always_comb begin
    w  = 16'h0000;
    st = c8enc_pkg::ST_NOMATCH;
    case (instr.action)
      c8enc_pkg::ACT_CLS: begin
        if (p0) begin w = 16'h00E0; st = c8enc_pkg::ST_OK; end
      end
      c8enc_pkg::ACT_RET: begin
        if (p0) begin w = 16'h00EE; st = c8enc_pkg::ST_OK; end
      end
      c8enc_pkg::ACT_SYS: begin
        if (p1a) begin w = a0; st = c8enc_pkg::ST_OK; end
      end
      c8enc_pkg::ACT_JP: begin
        // A register jump base must be V0
        if (!(cnt != 2'd0 && k0 == c8enc_pkg::KIND_V && v0 != 12'd0)) begin
          if (p1a) begin
            w = 16'h1000 | a0; st = c8enc_pkg::ST_OK;
          end else if (p2va) begin
            w = 16'hB000 | a1; st = c8enc_pkg::ST_OK;
          end
        end
      end
      c8enc_pkg::ACT_CALL: begin
        if (p1a) begin w = 16'h2000 | a0; st = c8enc_pkg::ST_OK; end
      end
      c8enc_pkg::ACT_SE, c8enc_pkg::ACT_SNE: begin
        if (p2vb) begin
          w = ((instr.action == c8enc_pkg::ACT_SE) ? 16'h3000 : 16'h4000) | rx | kk;
          st = c8enc_pkg::ST_OK;
        end else if (p2vv) begin
          w = ((instr.action == c8enc_pkg::ACT_SE) ? 16'h5000 : 16'h9000) | rx | ry;
          st = c8enc_pkg::ST_OK;
        end
      end
      c8enc_pkg::ACT_LD: begin
        st = c8enc_pkg::ST_OK;
        if (p2vb)                                  w = 16'h6000 | rx | kk;
        else if (p2vv)                             w = 16'h8000 | rx | ry;
        else if (p2ia && v0 == c8enc_pkg::IREG_I)  w = 16'hA000 | a1;
        else if (p2vdt)                            w = 16'hF007 | rx;
        else if (p2vkey)                           w = 16'hF00A | rx;
        else if (p2dtv)                            w = 16'hF015 | ry8;
        else if (p2stv)                            w = 16'hF018 | ry8;
        else if (p2iv && v0 == c8enc_pkg::IREG_F)  w = 16'hF029 | ry8;
        else if (p2iv && v0 == c8enc_pkg::IREG_B)  w = 16'hF033 | ry8;
        else if (p2indv)                           w = 16'hF055 | ry8;
        else if (p2vind)                           w = 16'hF065 | rx;
        else                                       st = c8enc_pkg::ST_NOMATCH;
      end
      c8enc_pkg::ACT_ADD: begin
        st = c8enc_pkg::ST_OK;
        if (p2vb)                                  w = 16'h7000 | rx | kk;
        else if (p2vv)                             w = 16'h8004 | rx | ry;
        else if (p2iv && v0 == c8enc_pkg::IREG_I)  w = 16'hF01E | ry8;
        else                                       st = c8enc_pkg::ST_NOMATCH;
      end
      c8enc_pkg::ACT_OR: begin
        if (p2vv) begin w = 16'h8001 | rx | ry; st = c8enc_pkg::ST_OK; end
      end
      c8enc_pkg::ACT_AND: begin
        if (p2vv) begin w = 16'h8002 | rx | ry; st = c8enc_pkg::ST_OK; end
      end
      c8enc_pkg::ACT_XOR: begin
        if (p2vv) begin w = 16'h8003 | rx | ry; st = c8enc_pkg::ST_OK; end
      end
      c8enc_pkg::ACT_SUB: begin
        if (p2vv) begin w = 16'h8005 | rx | ry; st = c8enc_pkg::ST_OK; end
      end
      c8enc_pkg::ACT_SUBN: begin
        if (p2vv) begin w = 16'h8007 | rx | ry; st = c8enc_pkg::ST_OK; end
      end
      c8enc_pkg::ACT_SHR, c8enc_pkg::ACT_SHL: begin
        if (p2vv) begin
          w = ((instr.action == c8enc_pkg::ACT_SHR) ? 16'h8006 : 16'h800E) | rx | ry;
          st = c8enc_pkg::ST_OK;
        end else if (p1v) begin
          w = ((instr.action == c8enc_pkg::ACT_SHR) ? 16'h8006 : 16'h800E) | rx;
          st = c8enc_pkg::ST_OK;
        end
      end
      c8enc_pkg::ACT_RND: begin
        if (p2vb) begin w = 16'hC000 | rx | kk; st = c8enc_pkg::ST_OK; end
      end
      c8enc_pkg::ACT_DRW: begin
        if (p3vvn) begin
          w = 16'hD000 | rx | ry | {12'b0, v2[3:0]}; st = c8enc_pkg::ST_OK;
        end
      end
      c8enc_pkg::ACT_SKP: begin
        if (p1v) begin w = 16'hE09E | rx; st = c8enc_pkg::ST_OK; end
      end
      c8enc_pkg::ACT_SKNP: begin
        if (p1v) begin w = 16'hE0A1 | rx; st = c8enc_pkg::ST_OK; end
      end
      default: st = c8enc_pkg::ST_UNKNOWN;
    endcase
    // Word is zero on any failure
    if (st != c8enc_pkg::ST_OK) w = 16'h0000;
  end

  assign result.machine_word = w;
  assign result.status       = st;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the CHIP-8 instruction encoder stream block.
`timescale 1ns / 1ps

module testbench;
  import c8enc_pkg::*;

  // Fail the run if it goes past this many cycles.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1700;
  // Marks a pattern slot beyond the pattern length.
  localparam logic [3:0] SLOT_UNUSED = 4'd15;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [4:0] action, [6:5] num_args, [18:7] first_value, [30:19] second_value,
  // [42:31] third_value, [47:43] zero
  logic [47:0] in_tdata = '0;
  // [3:0] first_kind, [7:4] second_kind, [11:8] third_kind
  logic [11:0] in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [15:0] machine_word, [17:16] status, [23:18] zero
  logic [23:0] out_tdata;

  instr_t  instr_backlog[$];   // instructions not yet presented
  result_t due_words[$];       // predicted words, oldest first
  instr_t  held_instr;         // instruction currently on in_tdata/in_tuser
  int      in_gap = 0;
  int      out_stall = 0;
  bit      in_quiet = 1'b0;
  bit      out_quiet = 1'b0;
  int      cycle_count = 0;
  int      error_count = 0;
  int      sent_count = 0;
  int      n_encoded = 0;
  int      n_unknown = 0;
  int      n_rejected = 0;

  chip8_instruction_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Encoding predictor
  // ---------------------------------------------------------------------

  // Address slots take address/byte/nibble, byte slots take byte/nibble,
  // everything else needs the exact kind. Kinds 9..15 never fit.
  function automatic logic accepts(input logic [3:0] slot, input logic [3:0] kind);
    case (slot)
      KIND_A:  return kind == KIND_A || kind == KIND_B || kind == KIND_N;
      KIND_B:  return kind == KIND_B || kind == KIND_N;
      default: return slot <= KIND_ST && kind == slot;
    endcase
  endfunction

  // Count must equal the pattern length; slots past the length are ignored.
  function automatic logic fits_pattern(input instr_t t, input int len,
                                        input logic [3:0] s0, input logic [3:0] s1,
                                        input logic [3:0] s2);
    if (int'(t.num_args) != len) return 1'b0;
    if (len > 0 && !accepts(s0, t.first_kind)) return 1'b0;
    if (len > 1 && !accepts(s1, t.second_kind)) return 1'b0;
    if (len > 2 && !accepts(s2, t.third_kind)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic result_t encode_instr(input instr_t t);
    result_t     r;
    logic        hit;
    logic        known;
    logic [15:0] w;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [7:0]  kk;
    logic [3:0]  alu;
    hit   = 1'b0;
    known = 1'b1;
    w     = '0;
    x     = t.first_value[3:0];
    y     = t.second_value[3:0];
    kk    = t.second_value[7:0];
    alu   = 4'h0;
    case (t.action)
      ACT_CLS: begin
        hit = fits_pattern(t, 0, SLOT_UNUSED, SLOT_UNUSED, SLOT_UNUSED);
        w = 16'h00E0;
      end
      ACT_RET: begin
        hit = fits_pattern(t, 0, SLOT_UNUSED, SLOT_UNUSED, SLOT_UNUSED);
        w = 16'h00EE;
      end
      ACT_SYS: begin
        hit = fits_pattern(t, 1, KIND_A, SLOT_UNUSED, SLOT_UNUSED);
        w = {4'h0, t.first_value};
      end
      ACT_JP: begin
        // A register jump base must be V0; anything else rejects outright.
        if (!(t.num_args != 2'd0 && t.first_kind == KIND_V && t.first_value != 12'd0)) begin
          if (fits_pattern(t, 1, KIND_A, SLOT_UNUSED, SLOT_UNUSED)) begin
            hit = 1'b1;
            w = {4'h1, t.first_value};
          end else if (fits_pattern(t, 2, KIND_V, KIND_A, SLOT_UNUSED)) begin
            hit = 1'b1;
            w = {4'hB, t.second_value};
          end
        end
      end
      ACT_CALL: begin
        hit = fits_pattern(t, 1, KIND_A, SLOT_UNUSED, SLOT_UNUSED);
        w = {4'h2, t.first_value};
      end
      ACT_SE, ACT_SNE: begin
        if (fits_pattern(t, 2, KIND_V, KIND_B, SLOT_UNUSED)) begin
          hit = 1'b1;
          w = {(t.action == ACT_SE) ? 4'h3 : 4'h4, x, kk};
        end else if (fits_pattern(t, 2, KIND_V, KIND_V, SLOT_UNUSED)) begin
          hit = 1'b1;
          w = {(t.action == ACT_SE) ? 4'h5 : 4'h9, x, y, 4'h0};
        end
      end
      ACT_LD: begin
        hit = 1'b1;
        if (fits_pattern(t, 2, KIND_V, KIND_B, SLOT_UNUSED)) w = {4'h6, x, kk};
        else if (fits_pattern(t, 2, KIND_V, KIND_V, SLOT_UNUSED)) w = {4'h8, x, y, 4'h0};
        else if (fits_pattern(t, 2, KIND_I, KIND_A, SLOT_UNUSED) && t.first_value == IREG_I)
          w = {4'hA, t.second_value};
        else if (fits_pattern(t, 2, KIND_V, KIND_DT, SLOT_UNUSED)) w = {4'hF, x, 8'h07};
        else if (fits_pattern(t, 2, KIND_V, KIND_KEY, SLOT_UNUSED)) w = {4'hF, x, 8'h0A};
        else if (fits_pattern(t, 2, KIND_DT, KIND_V, SLOT_UNUSED)) w = {4'hF, y, 8'h15};
        else if (fits_pattern(t, 2, KIND_ST, KIND_V, SLOT_UNUSED)) w = {4'hF, y, 8'h18};
        else if (fits_pattern(t, 2, KIND_I, KIND_V, SLOT_UNUSED) && t.first_value == IREG_F)
          w = {4'hF, y, 8'h29};
        else if (fits_pattern(t, 2, KIND_I, KIND_V, SLOT_UNUSED) && t.first_value == IREG_B)
          w = {4'hF, y, 8'h33};
        else if (fits_pattern(t, 2, KIND_IND, KIND_V, SLOT_UNUSED)) w = {4'hF, y, 8'h55};
        else if (fits_pattern(t, 2, KIND_V, KIND_IND, SLOT_UNUSED)) w = {4'hF, x, 8'h65};
        else hit = 1'b0;
      end
      ACT_ADD: begin
        hit = 1'b1;
        if (fits_pattern(t, 2, KIND_V, KIND_B, SLOT_UNUSED)) w = {4'h7, x, kk};
        else if (fits_pattern(t, 2, KIND_V, KIND_V, SLOT_UNUSED)) w = {4'h8, x, y, 4'h4};
        else if (fits_pattern(t, 2, KIND_I, KIND_V, SLOT_UNUSED) && t.first_value == IREG_I)
          w = {4'hF, y, 8'h1E};
        else hit = 1'b0;
      end
      ACT_OR, ACT_AND, ACT_XOR, ACT_SUB, ACT_SUBN: begin
        case (t.action)
          ACT_OR:  alu = 4'h1;
          ACT_AND: alu = 4'h2;
          ACT_XOR: alu = 4'h3;
          ACT_SUB: alu = 4'h5;
          default: alu = 4'h7;
        endcase
        hit = fits_pattern(t, 2, KIND_V, KIND_V, SLOT_UNUSED);
        w = {4'h8, x, y, alu};
      end
      ACT_SHR, ACT_SHL: begin
        alu = (t.action == ACT_SHR) ? 4'h6 : 4'hE;
        if (fits_pattern(t, 2, KIND_V, KIND_V, SLOT_UNUSED)) begin
          hit = 1'b1;
          w = {4'h8, x, y, alu};
        end else if (fits_pattern(t, 1, KIND_V, SLOT_UNUSED, SLOT_UNUSED)) begin
          hit = 1'b1;
          w = {4'h8, x, 4'h0, alu};
        end
      end
      ACT_RND: begin
        hit = fits_pattern(t, 2, KIND_V, KIND_B, SLOT_UNUSED);
        w = {4'hC, x, kk};
      end
      ACT_DRW: begin
        hit = fits_pattern(t, 3, KIND_V, KIND_V, KIND_N);
        w = {4'hD, x, y, t.third_value[3:0]};
      end
      ACT_SKP: begin
        hit = fits_pattern(t, 1, KIND_V, SLOT_UNUSED, SLOT_UNUSED);
        w = {4'hE, x, 8'h9E};
      end
      ACT_SKNP: begin
        hit = fits_pattern(t, 1, KIND_V, SLOT_UNUSED, SLOT_UNUSED);
        w = {4'hE, x, 8'hA1};
      end
      default: known = 1'b0;
    endcase
    r.status       = !known ? ST_UNKNOWN : (hit ? ST_OK : ST_NOMATCH);
    r.machine_word = (known && hit) ? w : 16'h0000;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Instruction generators
  // ---------------------------------------------------------------------

  function automatic instr_t instr(input logic [4:0] action, input logic [1:0] count,
                                   input logic [3:0] k0, input logic [11:0] v0,
                                   input logic [3:0] k1, input logic [11:0] v1,
                                   input logic [3:0] k2, input logic [11:0] v2);
    instr_t t;
    t.action       = action;
    t.num_args     = count;
    t.first_kind   = k0;
    t.first_value  = v0;
    t.second_kind  = k1;
    t.second_value = v1;
    t.third_kind   = k2;
    t.third_value  = v2;
    return t;
  endfunction

  function automatic instr_t noise_instr();
    return instr(5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)),
                 4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)),
                 4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)),
                 4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
  endfunction

  // Set count and the leading kinds; values and trailing kinds stay random.
  function automatic instr_t shape(input instr_t t, input int count,
                                   input logic [3:0] k0, input logic [3:0] k1);
    t.num_args    = 2'(count);
    t.first_kind  = k0;
    t.second_kind = k1;
    return t;
  endfunction

  function automatic logic [3:0] addr_kind();
    case ($urandom_range(0, 4))
      0:       return KIND_B;
      1:       return KIND_N;
      default: return KIND_A;
    endcase
  endfunction

  function automatic logic [3:0] byte_kind();
    return ($urandom_range(0, 2) == 0) ? KIND_N : KIND_B;
  endfunction

  // Mostly the required register number, sometimes any value.
  function automatic logic [11:0] reg_value(input logic [11:0] want);
    return ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095)) : want;
  endfunction

  function automatic instr_t well_formed_instr();
    instr_t t;
    int     pick;
    t = noise_instr();
    pick = $urandom_range(0, 10);
    t.action = 5'($urandom_range(0, 19));
    case (t.action)
      ACT_CLS, ACT_RET: t.num_args = 2'd0;
      ACT_SYS, ACT_CALL: t = shape(t, 1, addr_kind(), t.second_kind);
      ACT_JP: begin
        if (pick < 5) begin
          t = shape(t, 1, addr_kind(), t.second_kind);
        end else begin
          t = shape(t, 2, KIND_V, addr_kind());
          t.first_value = reg_value(12'd0);
        end
      end
      ACT_SE, ACT_SNE: t = shape(t, 2, KIND_V, (pick < 5) ? byte_kind() : KIND_V);
      ACT_LD: begin
        case (pick)
          0: t = shape(t, 2, KIND_V, byte_kind());
          1: t = shape(t, 2, KIND_V, KIND_V);
          2: begin
            t = shape(t, 2, KIND_I, addr_kind());
            t.first_value = reg_value(IREG_I);
          end
          3: t = shape(t, 2, KIND_V, KIND_DT);
          4: t = shape(t, 2, KIND_V, KIND_KEY);
          5: t = shape(t, 2, KIND_DT, KIND_V);
          6: t = shape(t, 2, KIND_ST, KIND_V);
          7: begin
            t = shape(t, 2, KIND_I, KIND_V);
            t.first_value = reg_value(IREG_F);
          end
          8: begin
            t = shape(t, 2, KIND_I, KIND_V);
            t.first_value = reg_value(IREG_B);
          end
          9: t = shape(t, 2, KIND_IND, KIND_V);
          default: t = shape(t, 2, KIND_V, KIND_IND);
        endcase
      end
      ACT_ADD: begin
        case (pick % 3)
          0: t = shape(t, 2, KIND_V, byte_kind());
          1: t = shape(t, 2, KIND_V, KIND_V);
          default: begin
            t = shape(t, 2, KIND_I, KIND_V);
            t.first_value = reg_value(IREG_I);
          end
        endcase
      end
      ACT_SHR, ACT_SHL: t = shape(t, (pick < 5) ? 1 : 2, KIND_V, KIND_V);
      ACT_RND: t = shape(t, 2, KIND_V, byte_kind());
      ACT_DRW: begin
        t = shape(t, 3, KIND_V, KIND_V);
        t.third_kind = KIND_N;
      end
      ACT_SKP, ACT_SKNP: t = shape(t, 1, KIND_V, t.second_kind);
      default: t = shape(t, 2, KIND_V, KIND_V);
    endcase
    return t;
  endfunction

  // Mostly well-formed, some broken near-misses, the rest raw noise.
  function automatic instr_t random_instr();
    instr_t t;
    int     roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return noise_instr();
    t = well_formed_instr();
    if (roll < 37) begin
      case ($urandom_range(0, 2))
        0: t.num_args = t.num_args ^ 2'($urandom_range(1, 3));
        1: t.first_kind = 4'($urandom_range(0, 15));
        default: t.second_kind = 4'($urandom_range(9, 15));
      endcase
    end
    return t;
  endfunction

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: present backlog instructions, record the prediction on transfer
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_instr
    logic slot_free;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = draw_gap(in_quiet);
    end else begin
      if (in_tvalid && in_tready) begin
        due_words.push_back(encode_instr(held_instr));
        sent_count++;
        in_gap = draw_gap(in_quiet);
      end
      // Hold the current item until it transfers.
      slot_free = !in_tvalid || in_tready;
      if (slot_free) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (instr_backlog.size() != 0) begin
          held_instr = instr_backlog.pop_front();
          in_tdata  <= {5'b0, held_instr.third_value, held_instr.second_value,
                        held_instr.first_value, held_instr.num_args, held_instr.action};
          in_tuser  <= {held_instr.third_kind, held_instr.second_kind, held_instr.first_kind};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check each result transfer and draw the next receiver stall
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = draw_gap(out_quiet);
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_words.size() == 0) begin
          $error("unexpected result: machine_word %h status %0d",
                 out_tdata[15:0], out_tdata[17:16]);
          error_count++;
        end else begin
          want = due_words.pop_front();
          if (out_tdata[15:0] !== want.machine_word) begin
            $error("machine_word: expected %h, got %h", want.machine_word, out_tdata[15:0]);
            error_count++;
          end
          if (out_tdata[17:16] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[17:16]);
            error_count++;
          end
        end
        case (out_tdata[17:16])
          ST_OK:      n_encoded++;
          ST_UNKNOWN: n_unknown++;
          default:    n_rejected++;
        endcase
        out_stall = draw_gap(out_quiet);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Alternate stretches of heavy idling with stretches of none; bound the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 256 == 0) begin
      in_quiet  <= ($urandom_range(0, 3) == 0);
      out_quiet <= ($urandom_range(0, 3) == 0);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    // Directed: every mnemonic, field extremes and the special cases.
    instr_backlog.push_back(instr(ACT_CLS, 2'd0, 4'd15, 12'hFFF, 4'd15, 12'hFFF, 4'd15, 12'hFFF));
    instr_backlog.push_back(instr(ACT_RET, 2'd0, KIND_V, 12'h000, KIND_V, 12'h000, KIND_V, 12'h000));
    instr_backlog.push_back(instr(ACT_SYS, 2'd1, KIND_A, 12'hFFF, 4'd9, 12'h0, 4'd9, 12'h0));
    instr_backlog.push_back(instr(ACT_JP, 2'd1, KIND_N, 12'h005, KIND_V, 12'h0, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_JP, 2'd2, KIND_V, 12'h000, KIND_A, 12'hABC, KIND_V, 12'h0));
    // register jump that does not name V0
    instr_backlog.push_back(instr(ACT_JP, 2'd2, KIND_V, 12'h001, KIND_A, 12'h123, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_CALL, 2'd1, KIND_B, 12'h0FF, KIND_V, 12'h0, KIND_V, 12'h0));
    // wide values truncate to register nibble and byte
    instr_backlog.push_back(instr(ACT_SE, 2'd2, KIND_V, 12'hFFF, KIND_B, 12'hFFF, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_SNE, 2'd2, KIND_V, 12'h003, KIND_V, 12'h00A, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_LD, 2'd2, KIND_I, IREG_I, KIND_A, 12'hFFF, KIND_V, 12'h0));
    // I-register operands, one paired with the wrong second operand
    instr_backlog.push_back(instr(ACT_LD, 2'd2, KIND_I, IREG_F, KIND_A, 12'h200, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_LD, 2'd2, KIND_I, IREG_F, KIND_V, 12'h005, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_LD, 2'd2, KIND_I, IREG_B, KIND_V, 12'h007, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_LD, 2'd2, KIND_DT, 12'h0, KIND_V, 12'h00C, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_LD, 2'd2, KIND_V, 12'h00E, KIND_KEY, 12'h0, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_LD, 2'd2, KIND_IND, 12'h0, KIND_V, 12'h00F, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_ADD, 2'd2, KIND_I, IREG_I, KIND_V, 12'h009, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_ADD, 2'd2, KIND_I, IREG_B, KIND_V, 12'h009, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_OR, 2'd2, KIND_V, 12'h001, KIND_V, 12'h002, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_AND, 2'd2, KIND_V, 12'h003, KIND_V, 12'h004, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_XOR, 2'd2, KIND_V, 12'h005, KIND_V, 12'h006, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_SUB, 2'd2, KIND_V, 12'h007, KIND_V, 12'h008, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_SUBN, 2'd2, KIND_V, 12'h009, KIND_V, 12'h00A, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_SHR, 2'd1, KIND_V, 12'h00B, 4'd15, 12'hFFF, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_SHL, 2'd2, KIND_V, 12'h00C, KIND_V, 12'h00D, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_RND, 2'd2, KIND_V, 12'h00E, KIND_N, 12'h0AB, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_DRW, 2'd3, KIND_V, 12'h001, KIND_V, 12'h002, KIND_N, 12'hFFF));
    instr_backlog.push_back(instr(ACT_SKP, 2'd1, KIND_V, 12'h004, KIND_V, 12'h0, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_SKNP, 2'd1, KIND_V, 12'h005, KIND_V, 12'h0, KIND_V, 12'h0));
    // unknown mnemonics, error kind, argument count mismatch
    instr_backlog.push_back(instr(5'd20, 2'd0, KIND_V, 12'h0, KIND_V, 12'h0, KIND_V, 12'h0));
    instr_backlog.push_back(instr(5'd31, 2'd3, 4'd15, 12'hFFF, 4'd15, 12'hFFF, 4'd15, 12'hFFF));
    instr_backlog.push_back(instr(ACT_SE, 2'd2, KIND_V, 12'h001, 4'd9, 12'h002, KIND_V, 12'h0));
    instr_backlog.push_back(instr(ACT_CLS, 2'd3, KIND_V, 12'h0, KIND_V, 12'h0, KIND_V, 12'h0));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      instr_backlog.push_back(random_instr());
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent and every predicted word checked.
    while (instr_backlog.size() != 0 || in_tvalid || due_words.size() != 0) begin
      @(negedge clk);
    end
    // Let any stray extra result surface.
    repeat (8) @(posedge clk);

    $display("Sent %0d instructions over %0d cycles with random idling on both sides",
             sent_count, cycle_count);
    $display("Results: %0d encoded, %0d unknown mnemonic, %0d rejected by pattern check",
             n_encoded, n_unknown, n_rejected);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
